@@ hw/rtl/lrs_pkg.sv @@
`default_nettype none

package lrs_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT       = 8;
   localparam int INDEX_WIDTH_DEFAULT = 16;

   // Fixed widths of the channel fields.
   localparam int REQ_TYPE_W = 1;
   localparam int FIELD_IDX_W = 16;
   localparam int STATUS_W = 3;
   localparam int FILL_W = 4;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_TOUCH = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_EVICT = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic update;    // a word is accepted this cycle
      logic touch_go;  // touch that changes the stack (hit, or insert with room)
   } lrs_cell_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/lrs_req_if.sv @@
`default_nettype none

interface lrs_req_if;
   import lrs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [FIELD_IDX_W-1:0] touched_index;

   modport source (output valid, output req_type, output touched_index, input ready);
   modport sink (input valid, input req_type, input touched_index, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lrs_rsp_if.sv @@
`default_nettype none

interface lrs_rsp_if;
   import lrs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [FIELD_IDX_W-1:0] victim_index;
   logic [FILL_W-1:0]      fill_count;

   modport source (output valid, output status, output victim_index, output fill_count,
                   input ready);
   modport sink (input valid, input status, input victim_index, input fill_count,
                 output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lrs_cell.sv @@
`default_nettype none

// One place of the recency stack. It compares its entry with the touched key,
// takes its neighbor's entry when the stack shifts through it, and offers its
// entry as the victim when it holds the oldest valid entry.
module lrs_cell #(
   parameter int INDEX_WIDTH = 16,
   parameter int CELL_INDEX  = 0,
   parameter int CNT_W       = 4
) (
   input  wire                             clock,
   input  wire lrs_pkg::lrs_cell_ctl_type  ctl,
   input  wire [INDEX_WIDTH-1:0]           key,
   input  wire [CNT_W-1:0]                 count,
   input  wire [INDEX_WIDTH-1:0]           prev_entry,
   input  wire                             hit_seen_in,
   input  wire [INDEX_WIDTH-1:0]           victim_in,
   output logic [INDEX_WIDTH-1:0]          entry,
   output logic                            hit_seen_out,
   output logic [INDEX_WIDTH-1:0]          victim_out
);
   import lrs_pkg::*;

   localparam logic [CNT_W-1:0] MY_PLACE  = CNT_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] NEXT_FILL = CNT_W'(CELL_INDEX + 1);

   logic [INDEX_WIDTH-1:0] entry_ff;
   logic [INDEX_WIDTH-1:0] entry_in;
   logic                   valid;
   logic                   is_last;
   logic                   shift;

   assign valid   = (count > MY_PLACE);
   assign is_last = (count == NEXT_FILL);

   assign hit_seen_out = hit_seen_in | (valid && (entry_ff == key));
   assign victim_out   = victim_in | (is_last ? entry_ff : '0);

   // Cells up to and including the hit place shift back by one; on an insert
   // every cell shifts.
   assign shift    = ctl.update && ctl.touch_go && !hit_seen_in;
   assign entry_in = shift ? prev_entry : entry_ff;
   assign entry    = entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end
endmodule

`default_nettype wire

@@ hw/rtl/lru_recency_stack.sv @@
`default_nettype none

// LRU recency stack: keeps up to DEPTH block indices ordered by recency,
// most recent in cell 0.
// The req channel takes one word per request: req_type selects a touch
// (move a held index to the front, or insert a new one) or an evict of the
// least recently used entry. The rsp channel returns one word per request
// with the status, the evicted index (zero unless an evict succeeds) and the
// fill count after the request.
// A result is registered and appears on rsp the cycle after its request is
// accepted. Throughput is one request per cycle while the receiver keeps up,
// set by the cell chain, which compares every entry and shifts the stack at once.
// The result sits in an output register; req.ready stays high while that
// register is empty or being drained, so a stalled receiver holds back only
// the next request, and a waiting result is never overwritten.
// Reset empties the stack and drops any pending result. Entry contents are
// not cleared; places beyond the fill count are never compared or read.
// A touch of a new index on a full stack is refused with the full status;
// an evict on an empty stack returns the empty status.
module lru_recency_stack #(
   parameter int DEPTH       = lrs_pkg::DEPTH_DEFAULT,
   parameter int INDEX_WIDTH = lrs_pkg::INDEX_WIDTH_DEFAULT
) (
   input wire   clock,
   input wire   reset,
   lrs_req_if.sink   req,
   lrs_rsp_if.source rsp
);
   import lrs_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // Stack fill and the registered response word.
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [STATUS_W-1:0]    status_in;
   logic [FIELD_IDX_W-1:0] victim_ff;
   logic [FIELD_IDX_W-1:0] victim_in;
   logic [FILL_W-1:0]      fill_ff;
   logic [FILL_W-1:0]      fill_in;

   logic                   accept;
   logic                   is_touch;
   logic                   any_hit;
   logic                   full;
   logic                   empty;
   logic [31:0]            key_wide;
   logic [INDEX_WIDTH-1:0] key;
   logic [31:0]            victim_wide;
   logic [31:0]            count_wide;
   lrs_cell_ctl_type       ctl;

   // Chain wires between neighboring cells.
   logic [INDEX_WIDTH-1:0] chain_entry [DEPTH+1];
   logic                   chain_hit [DEPTH+1];
   logic [INDEX_WIDTH-1:0] chain_victim [DEPTH+1];

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Indices are kept at INDEX_WIDTH bits; wider request bits are dropped.
   assign key_wide = 32'(req.touched_index);
   assign key      = key_wide[INDEX_WIDTH-1:0];

   assign is_touch = (req.req_type == REQ_TOUCH);
   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign any_hit  = chain_hit[DEPTH];

   assign ctl.update   = accept;
   assign ctl.touch_go = is_touch && (any_hit || !full);

   // The front cell takes the touched key itself.
   assign chain_entry[0]  = key;
   assign chain_hit[0]    = 1'b0;
   assign chain_victim[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      lrs_cell #(
         .INDEX_WIDTH (INDEX_WIDTH),
         .CELL_INDEX  (i),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .key          (key),
         .count        (count_ff),
         .prev_entry   (chain_entry[i]),
         .hit_seen_in  (chain_hit[i]),
         .victim_in    (chain_victim[i]),
         .entry        (chain_entry[i+1]),
         .hit_seen_out (chain_hit[i+1]),
         .victim_out   (chain_victim[i+1])
      );
   end

   assign victim_wide = 32'(chain_victim[DEPTH]);

   // Request decode: new count and the response word.
   always_comb begin
      count_in  = count_ff;
      status_in = ST_HIT;
      victim_in = '0;
      if (is_touch) begin
         if (any_hit) begin
            status_in = ST_HIT;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERT;
            count_in  = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_EVICT;
            victim_in = victim_wide[FIELD_IDX_W-1:0];
            count_in  = count_ff - CNT_W'(1);
         end
      end
   end

   assign count_wide   = 32'(count_in);
   assign fill_in      = count_wide[FILL_W-1:0];
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         victim_ff <= victim_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.victim_index = victim_ff;
   assign rsp.fill_count   = fill_ff;

   // The fill count never passes the stack depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond stack depth");

   // An evict on an empty stack reports the empty status and keeps the count.
   a_empty_evict: assert property (@(posedge clock) disable iff (reset)
      accept && !is_touch && empty |=> rsp_valid_ff && (status_ff == ST_EMPTY)
         && (count_ff == '0))
      else $error("evict on empty stack not reported");

   // An insert grows the stack by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && is_touch && !any_hit && !full
         |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))) && (status_ff == ST_INSERT))
      else $error("insert did not grow the stack");

   // A touch on a full stack that misses leaves the count unchanged.
   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && is_touch && !any_hit && full |=> (count_ff == FULL_COUNT)
         && (status_ff == ST_FULL))
      else $error("full stack accepted a new index");
endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

// Self-checking bench for the LRU recency stack.
//
// A queue of request words is built up front: a short directed sequence that
// walks the stack through empty, partly filled and full states, followed by
// random episodes that draw most touches from a small pool of indices. The
// small pool is what makes hits, full refusals and evictions of known entries
// common; a uniform draw over 16 bits would almost never hit.
//
// A clocked driver feeds the request channel from that queue. Before each
// word it waits a random number of idle cycles. Some words carry a drain
// mark, and the driver holds them back until every earlier request has been
// answered.
//
// A clocked monitor keeps a shadow copy of the stack. For every accepted
// request it predicts the response word and pushes it on a FIFO. Every
// accepted response is compared field by field against the oldest
// prediction.
//
// The receiver stalls at random. A separate process also makes it hold off
// for a long stretch, twice, so that the output register fills and the block
// stalls its request side.
module tb;
   import lrs_pkg::*;

   localparam int LRU_DEPTH    = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1830;
   localparam int LONG_HOLD    = 48;
   localparam int TAIL_CYCLES  = 4;

   // One request word as the driver sees it.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0]  kind;
      logic [FIELD_IDX_W-1:0] index;
   } lru_access_type;

   // A request word plus the idle cycles that come before it, and whether
   // the driver must wait for all earlier responses first.
   typedef struct {
      lru_access_type acc;
      int unsigned    gap;
      bit             drain_first;
   } queued_access_type;

   // One response word.
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [FIELD_IDX_W-1:0] victim;
      logic [FILL_W-1:0]      fill;
   } lru_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lrs_req_if req_ch ();
   lrs_rsp_if rsp_ch ();

   lru_recency_stack i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   queued_access_type pending_accesses [$];
   lru_outcome_type   predicted_outcomes [$];

   // Shadow of the stack contents; entry 0 is the most recently used.
   logic [FIELD_IDX_W-1:0] shadow_stack [LRU_DEPTH];
   int unsigned            shadow_fill;

   int unsigned mismatch_count;
   int          outstanding;      // requests accepted but not yet answered
   int unsigned hold_left;        // cycles left in a long receiver hold-off
   int unsigned words_accepted;
   int unsigned cycle_count;

   // Driver bookkeeping, touched only inside the driver process.
   int unsigned       send_gap_left;
   bit                send_gap_armed;
   int                in_flight;
   queued_access_type next_access;

   // Receiver bookkeeping.
   int unsigned take_stall_left;
   int unsigned results_taken;

   // Monitor bookkeeping.
   lru_outcome_type wanted;

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Applies one request to the shadow stack and returns the response word
   // that the block must give for it.
   function automatic lru_outcome_type predict_lru_access(input lru_access_type acc);
      lru_outcome_type res;
      bit              found;
      int unsigned     pos;
      int              k;

      res    = '0;
      found  = 1'b0;
      pos    = 0;
      for (k = 0; k < int'(shadow_fill); k++) begin
         if (!found && shadow_stack[k] == acc.index) begin
            found = 1'b1;
            pos   = k;
         end
      end

      if (acc.kind == REQ_TOUCH) begin
         if (found) begin
            // A hit rotates the entries ahead of it back by one place.
            for (k = pos; k > 0; k--) begin
               shadow_stack[k] = shadow_stack[k-1];
            end
            shadow_stack[0] = acc.index;
            res.status = ST_HIT;
         end else if (shadow_fill >= LRU_DEPTH) begin
            // A new index on a full stack is refused and nothing moves.
            res.status = ST_FULL;
         end else begin
            for (k = shadow_fill; k > 0; k--) begin
               shadow_stack[k] = shadow_stack[k-1];
            end
            shadow_stack[0] = acc.index;
            shadow_fill++;
            res.status = ST_INSERT;
         end
      end else begin
         if (shadow_fill == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.victim = shadow_stack[shadow_fill-1];
            shadow_fill--;
            res.status = ST_EVICT;
         end
      end
      res.fill = shadow_fill[FILL_W-1:0];
      return res;
   endfunction

   function automatic void queue_access(input logic [REQ_TYPE_W-1:0] kind,
                                        input logic [FIELD_IDX_W-1:0] index,
                                        input int unsigned gap,
                                        input bit drain_first);
      queued_access_type q;
      q.acc.kind    = kind;
      q.acc.index   = index;
      q.gap         = gap;
      q.drain_first = drain_first;
      pending_accesses.push_back(q);
   endfunction

   // Request driver. A new word goes out only when the channel is free or
   // the current word is being taken at this edge, so valid stays high
   // across back-to-back words without being dropped in between.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         send_gap_armed = 1'b0;
         send_gap_left  = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // Requests still unanswered once this edge's handshakes land.
         in_flight = outstanding + (req_ch.valid && req_ch.ready)
                     - (rsp_ch.valid && rsp_ch.ready);
         if (pending_accesses.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else begin
            if (!send_gap_armed) begin
               send_gap_left  = pending_accesses[0].gap;
               send_gap_armed = 1'b1;
            end
            if (send_gap_left != 0) begin
               send_gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_accesses[0].drain_first && in_flight != 0) begin
               req_ch.valid <= 1'b0;
            end else begin
               next_access = pending_accesses.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.req_type      <= next_access.acc.kind;
               req_ch.touched_index <= next_access.acc.index;
               send_gap_armed = 1'b0;
            end
         end
      end
   end

   // Response receiver. After each taken word it draws a random stall. Every
   // fourth block of 128 results runs with no stalls at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_stall_left = 0;
         results_taken   = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            take_stall_left = ((results_taken / 128) % 4 == 1) ? 0 : $urandom_range(0, 4);
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (take_stall_left != 0) begin
            take_stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Long hold-off on the response side. It starts when the 400th and the
   // 1300th request words are taken. The driver keeps offering words, so the
   // block's output register fills and req.ready must drop.
   always @(posedge clock) begin
      if (reset) begin
         hold_left      <= 0;
         words_accepted <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            words_accepted <= words_accepted + 1;
         end
         if (req_ch.valid && req_ch.ready
             && (words_accepted == 399 || words_accepted == 1299)) begin
            hold_left <= LONG_HOLD;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // Monitor and scoreboard. The response is checked before this edge's
   // request is predicted. A response can then never be matched against a
   // prediction made at the same edge, and a stray response shows up as
   // unexpected.
   always @(posedge clock) begin
      if (reset) begin
         outstanding <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch($sformatf("response with nothing outstanding: status %0d",
                                         rsp_ch.status));
            end else begin
               wanted = predicted_outcomes.pop_front();
               if (rsp_ch.status !== wanted.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, wanted.status));
               end
               if (rsp_ch.victim_index !== wanted.victim) begin
                  report_mismatch($sformatf("victim_index 0x%04h, expected 0x%04h",
                                            rsp_ch.victim_index, wanted.victim));
               end
               if (rsp_ch.fill_count !== wanted.fill) begin
                  report_mismatch($sformatf("fill_count %0d, expected %0d",
                                            rsp_ch.fill_count, wanted.fill));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted_outcomes.push_back(
               predict_lru_access({req_ch.req_type, req_ch.touched_index}));
         end
         outstanding <= outstanding + (req_ch.valid && req_ch.ready)
                        - (rsp_ch.valid && rsp_ch.ready);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [FIELD_IDX_W-1:0] pool [12];
      int unsigned            pool_size;
      int unsigned            evict_pct;
      int unsigned            run_len;
      int unsigned            episode;
      int unsigned            made;
      bit                     quiet;
      int unsigned            p;
      int unsigned            j;
      int unsigned            roll;

      req_ch.valid         = 1'b0;
      req_ch.req_type      = REQ_TOUCH;
      req_ch.touched_index = '0;
      rsp_ch.ready         = 1'b0;
      mismatch_count       = 0;
      cycle_count          = 0;
      shadow_fill          = 0;
      for (p = 0; p < LRU_DEPTH; p++) begin
         shadow_stack[p] = '0;
      end

      // Directed part. It starts with an evict on the empty stack, then
      // inserts and hits at the index extremes. It fills the stack, tries a
      // new index on the full stack, hits the oldest and the newest entry
      // while full, and empties the stack again. The last evict finds it
      // empty once more. Evicts carry all-ones indices, which must be
      // ignored.
      queue_access(REQ_EVICT, 16'hFFFF, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h0000, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'hFFFF, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h0000, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'hFFFF, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h5555, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'hAAAA, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h0001, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h8000, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h1234, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h7FFF, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h4321, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h0000, $urandom_range(0, 4), 1'b0);
      queue_access(REQ_TOUCH, 16'h0000, $urandom_range(0, 4), 1'b0);
      for (p = 0; p < LRU_DEPTH + 1; p++) begin
         queue_access(REQ_EVICT, 16'hFFFF, $urandom_range(0, 4), 1'b0);
      end

      // Random part, in episodes. Each episode has its own pool of indices,
      // its own evict rate and its own pacing. Some episodes send their words back
      // to back, and every fourth one first waits for the block to drain. About
      // one touch in ten uses a fully random index.
      made    = 0;
      episode = 0;
      while (made < RANDOM_WORDS) begin
         pool_size = $urandom_range(4, 12);
         for (p = 0; p < pool_size; p++) begin
            roll = $urandom_range(0, 7);
            if (roll == 0) begin
               pool[p] = 16'h0000;
            end else if (roll == 1) begin
               pool[p] = 16'hFFFF;
            end else begin
               pool[p] = 16'($urandom_range(0, 65535));
            end
         end
         evict_pct = $urandom_range(5, 50);
         quiet     = ($urandom_range(0, 3) == 0);
         run_len   = $urandom_range(20, 60);
         for (j = 0; j < run_len && made < RANDOM_WORDS; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < evict_pct) begin
               queue_access(REQ_EVICT, 16'($urandom_range(0, 65535)),
                            quiet ? 0 : $urandom_range(0, 4),
                            j == 0 && episode % 4 == 0);
            end else if (roll % 10 == 0) begin
               queue_access(REQ_TOUCH, 16'($urandom_range(0, 65535)),
                            quiet ? 0 : $urandom_range(0, 4),
                            j == 0 && episode % 4 == 0);
            end else begin
               queue_access(REQ_TOUCH, pool[$urandom_range(0, pool_size - 1)],
                            quiet ? 0 : $urandom_range(0, 4),
                            j == 0 && episode % 4 == 0);
            end
            made++;
         end
         episode++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for everything to be sent and answered. The check is made at
      // the falling edge, where all of the rising edge's updates have
      // settled.
      @(negedge clock);
      while (pending_accesses.size() != 0 || req_ch.valid || outstanding != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (predicted_outcomes.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", predicted_outcomes.size()));
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_req_if.sv
hw/rtl/lrs_rsp_if.sv
hw/rtl/lrs_cell.sv
hw/rtl/lru_recency_stack.sv
tb/tb.sv
